FILE: design/ibs_pkg.sv
package ibs_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int POS_BITS    = 31;
	localparam int CHROM_BITS  = 8;
	localparam int TYPE_BITS   = 3;
	localparam int TAG_BITS    = 32;
	localparam int STATUS_BITS = 3;
	localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);

	localparam int MEAN_BITS   = 16;
	localparam int SD_BITS     = 16;
	localparam int MULT_BITS   = 8;
	localparam int PROD_BITS   = SD_BITS + MULT_BITS;
	localparam int MARGIN_BITS = PROD_BITS + 1;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 16;

	// Probe points are signed and wide enough that an add or a subtract never wraps.
	localparam int POINT_BITS = ((POS_BITS > MARGIN_BITS) ? POS_BITS : MARGIN_BITS) + 2;

	// Hit reduction: the cell hit bits are ORed in registered groups.
	localparam int GROUP_SIZE = 16;
	localparam int NUM_GROUPS = (TABLE_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_SCREEN = 1'b1;

	localparam logic [TYPE_BITS-1:0] TYPE_FLIP_LEFT  = 3'd3;
	localparam logic [TYPE_BITS-1:0] TYPE_FLIP_RIGHT = 3'd2;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_MEAN = 2'd0,
		CFG_SD   = 2'd1,
		CFG_MULT = 2'd2
	} cfg_index_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_KEPT       = 3'd0,
		ST_DROP_LEFT  = 3'd1,
		ST_DROP_RIGHT = 3'd2,
		ST_STORED     = 3'd3,
		ST_FULL       = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INSERT,
		S_MARGIN,
		S_POINTS,
		S_PROBE,
		S_REDUCE,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [CHROM_BITS-1:0] chrom;
		logic [POS_BITS-1:0]   pos_start;
		logic [POS_BITS-1:0]   pos_end;
	} entry_t;

	// Ordering flags a cell hands to its right-hand neighbour.
	typedef struct packed {
		logic ins;
		logic left;
		logic right;
	} order_t;

	// Broadcast from the controller to every cell.
	typedef struct packed {
		logic                         ins_en;
		logic [CHROM_BITS-1:0]        chrom;
		logic [POS_BITS-1:0]          pos_first;
		logic [POS_BITS-1:0]          pos_second;
		logic signed [POINT_BITS-1:0] left;
		logic signed [POINT_BITS-1:0] right;
	} cmd_t;

endpackage

FILE: design/ibs_if.sv
interface ibs_req_if;
	logic                            valid;
	logic                            ready;
	logic                            cmd;
	logic [ibs_pkg::CHROM_BITS-1:0]  chrom_id;
	logic [ibs_pkg::POS_BITS-1:0]    pos_first;
	logic [ibs_pkg::POS_BITS-1:0]    pos_second;
	logic [ibs_pkg::TYPE_BITS-1:0]   cluster_type;
	logic [ibs_pkg::TAG_BITS-1:0]    tag;

	modport source (
		output valid, cmd, chrom_id, pos_first, pos_second, cluster_type, tag,
		input  ready
	);
	modport sink (
		input  valid, cmd, chrom_id, pos_first, pos_second, cluster_type, tag,
		output ready
	);
endinterface

interface ibs_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [ibs_pkg::STATUS_BITS-1:0]  status;
	logic [ibs_pkg::TAG_BITS-1:0]     tag_out;

	modport source (
		output valid, status, tag_out,
		input  ready
	);
	modport sink (
		input  valid, status, tag_out,
		output ready
	);
endinterface

FILE: design/ibs_cell.sv
module ibs_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            used,
	input  ibs_pkg::cmd_t   cmd,
	input  ibs_pkg::entry_t prev_entry,
	input  ibs_pkg::order_t prev_order,
	output ibs_pkg::entry_t entry,
	output ibs_pkg::order_t order,
	output logic            hit_left_s1,
	output logic            hit_right_s1
);

	ibs_pkg::entry_t                       entry_q;
	logic signed [ibs_pkg::POINT_BITS-1:0] start_w;
	logic signed [ibs_pkg::POINT_BITS-1:0] end_w;
	logic                                  chrom_lt;
	logic                                  chrom_eq;
	logic                                  hit_left;
	logic                                  hit_right;

	assign entry = entry_q;

	always_comb begin
		start_w  = ibs_pkg::POINT_BITS'(entry_q.pos_start);
		end_w    = ibs_pkg::POINT_BITS'(entry_q.pos_end);
		chrom_lt = entry_q.chrom < cmd.chrom;
		chrom_eq = entry_q.chrom == cmd.chrom;

		order.ins   = used && (chrom_lt || (chrom_eq && entry_q.pos_end <= cmd.pos_second));
		order.left  = used && (chrom_lt || (chrom_eq && end_w < cmd.left));
		order.right = used && (chrom_lt || (chrom_eq && end_w < cmd.right));

		// This cell is the lower bound when it is the first one not ordered before the point.
		hit_left  = used && prev_order.left && !order.left && chrom_eq &&
			start_w <= cmd.left && cmd.left <= end_w;
		hit_right = used && prev_order.right && !order.right && chrom_eq &&
			start_w <= cmd.right && cmd.right <= end_w;
	end

	// On an insert, cells past the insertion point take their left neighbour's entry.
	always_ff @(posedge clk) begin
		if (cmd.ins_en && !order.ins) begin
			if (prev_order.ins) begin
				entry_q.chrom     <= cmd.chrom;
				entry_q.pos_start <= cmd.pos_first;
				entry_q.pos_end   <= cmd.pos_second;
			end else begin
				entry_q <= prev_entry;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_left_s1  <= 1'b0;
			hit_right_s1 <= 1'b0;
		end else begin
			hit_left_s1  <= hit_left;
			hit_right_s1 <= hit_right;
		end
	end

endmodule

FILE: design/ibs_hit_tree.sv
module ibs_hit_tree (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [ibs_pkg::TABLE_DEPTH-1:0]   hits,
	output logic                              any_hit
);

	localparam int PAD_BITS = ibs_pkg::NUM_GROUPS * ibs_pkg::GROUP_SIZE;

	logic [PAD_BITS-1:0]             padded;
	logic [ibs_pkg::NUM_GROUPS-1:0]  group_s2;

	assign padded = PAD_BITS'(hits);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_s2 <= '0;
		end else begin
			for (int g = 0; g < ibs_pkg::NUM_GROUPS; g++) begin
				group_s2[g] <= |padded[g*ibs_pkg::GROUP_SIZE +: ibs_pkg::GROUP_SIZE];
			end
		end
	end

	assign any_hit = |group_s2;

endmodule

FILE: design/interval_break_screen.sv
// Screens clusters against a sorted table of break intervals held in a row of
// TABLE_DEPTH cells, one interval per cell. Items are handled one at a time: a
// load's result reaches the output register after the insert step, in which
// every cell past the insertion point shifts one place right unless the table
// is full, and a screen's after the margin multiply, the probe points, the
// compare in every cell for both points at once, then a two-level OR over the
// cell hit bits whose first level is registered. The input is ready again in
// the cycle that follows the result's move into the output register. While an
// earlier result still waits in the output register, the next item is held in
// its last step and the input stays closed until that result is transferred.
// No clearing pass is needed after reset; only the fill count is cleared.
module interval_break_screen (
	input  logic                                clk,
	input  logic                                arst_n,
	ibs_req_if.sink                             req,
	ibs_rsp_if.source                           rsp,
	input  logic                                cfg_we,
	input  logic [ibs_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [ibs_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

	localparam int DEPTH = ibs_pkg::TABLE_DEPTH;

	ibs_pkg::state_t state_q, state_d;

	logic [ibs_pkg::MEAN_BITS-1:0]   mean_q;
	logic [ibs_pkg::SD_BITS-1:0]     sd_q;
	logic [ibs_pkg::MULT_BITS-1:0]   mult_q;

	logic                            cmd_q;
	logic [ibs_pkg::CHROM_BITS-1:0]  chrom_q;
	logic [ibs_pkg::POS_BITS-1:0]    first_q;
	logic [ibs_pkg::POS_BITS-1:0]    second_q;
	logic [ibs_pkg::TYPE_BITS-1:0]   type_q;
	logic [ibs_pkg::TAG_BITS-1:0]    tag_q;

	logic [ibs_pkg::CNT_BITS-1:0]    count_q;
	logic                            full;
	ibs_pkg::status_t                load_status_q;

	logic [ibs_pkg::PROD_BITS-1:0]   prod;
	logic [ibs_pkg::MARGIN_BITS-1:0] margin_q;
	logic signed [ibs_pkg::POINT_BITS-1:0] first_w, second_w, margin_w;
	logic signed [ibs_pkg::POINT_BITS-1:0] left_q, right_q;

	logic                            in_take;
	logic                            ins_en;
	logic                            out_load;
	ibs_pkg::status_t                res_status;
	ibs_pkg::cmd_t                   cell_cmd;

	logic                            out_valid_q;
	ibs_pkg::status_t                out_status_q;
	logic [ibs_pkg::TAG_BITS-1:0]    out_tag_q;

	ibs_pkg::entry_t                 entries [DEPTH];
	ibs_pkg::order_t                 orders  [DEPTH];
	logic [DEPTH-1:0]                hit_left_s1;
	logic [DEPTH-1:0]                hit_right_s1;
	logic                            any_left;
	logic                            any_right;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_q <= '0;
			sd_q   <= '0;
			mult_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				ibs_pkg::CFG_MEAN: mean_q <= cfg_wdata[ibs_pkg::MEAN_BITS-1:0];
				ibs_pkg::CFG_SD:   sd_q   <= cfg_wdata[ibs_pkg::SD_BITS-1:0];
				ibs_pkg::CFG_MULT: mult_q <= cfg_wdata[ibs_pkg::MULT_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign full = count_q == ibs_pkg::CNT_BITS'(DEPTH);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ibs_pkg::S_IDLE: begin
				if (req.valid) begin
					state_d = (req.cmd == ibs_pkg::CMD_LOAD) ? ibs_pkg::S_INSERT
						: ibs_pkg::S_MARGIN;
				end
			end
			ibs_pkg::S_INSERT: state_d = ibs_pkg::S_DONE;
			ibs_pkg::S_MARGIN: state_d = ibs_pkg::S_POINTS;
			ibs_pkg::S_POINTS: state_d = ibs_pkg::S_PROBE;
			ibs_pkg::S_PROBE:  state_d = ibs_pkg::S_REDUCE;
			ibs_pkg::S_REDUCE: state_d = ibs_pkg::S_DONE;
			ibs_pkg::S_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					state_d = ibs_pkg::S_IDLE;
				end
			end
			default: state_d = ibs_pkg::S_IDLE;
		endcase
	end

	// Controller outputs.
	always_comb begin
		req.ready = 1'b0;
		ins_en    = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ibs_pkg::S_IDLE:   req.ready = 1'b1;
			ibs_pkg::S_INSERT: ins_en = !full;
			ibs_pkg::S_DONE:   out_load = !out_valid_q || rsp.ready;
			default: ;
		endcase
	end

	assign in_take = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ibs_pkg::S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (ins_en) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			cmd_q    <= req.cmd;
			chrom_q  <= req.chrom_id;
			first_q  <= req.pos_first;
			second_q <= req.pos_second;
			type_q   <= req.cluster_type;
			tag_q    <= req.tag;
		end
		if (state_q == ibs_pkg::S_INSERT) begin
			load_status_q <= full ? ibs_pkg::ST_FULL : ibs_pkg::ST_STORED;
		end
	end

	// Margin, then the two probe points, each behind its own register.
	assign prod     = mult_q * sd_q;
	assign first_w  = ibs_pkg::POINT_BITS'(first_q);
	assign second_w = ibs_pkg::POINT_BITS'(second_q);
	assign margin_w = ibs_pkg::POINT_BITS'(margin_q);

	always_ff @(posedge clk) begin
		if (state_q == ibs_pkg::S_MARGIN) begin
			margin_q <= ibs_pkg::MARGIN_BITS'(mean_q) + ibs_pkg::MARGIN_BITS'(prod);
		end
		if (state_q == ibs_pkg::S_POINTS) begin
			left_q  <= (type_q == ibs_pkg::TYPE_FLIP_LEFT) ? first_w - margin_w
				: first_w + margin_w;
			right_q <= (type_q == ibs_pkg::TYPE_FLIP_RIGHT) ? second_w + margin_w
				: second_w - margin_w;
		end
	end

	always_comb begin
		cell_cmd.ins_en     = ins_en;
		cell_cmd.chrom      = chrom_q;
		cell_cmd.pos_first  = first_q;
		cell_cmd.pos_second = second_q;
		cell_cmd.left       = left_q;
		cell_cmd.right      = right_q;
	end

	// The cell row. The first cell sees an imaginary neighbour ordered before every key.
	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		ibs_pkg::entry_t prev_entry;
		ibs_pkg::order_t prev_order;
		logic            used;

		if (k == 0) begin : g_head
			assign prev_entry = entries[0];
			assign prev_order = '1;
		end else begin : g_link
			assign prev_entry = entries[k-1];
			assign prev_order = orders[k-1];
		end

		assign used = count_q > ibs_pkg::CNT_BITS'(k);

		ibs_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.used         (used),
			.cmd          (cell_cmd),
			.prev_entry   (prev_entry),
			.prev_order   (prev_order),
			.entry        (entries[k]),
			.order        (orders[k]),
			.hit_left_s1  (hit_left_s1[k]),
			.hit_right_s1 (hit_right_s1[k])
		);
	end

	ibs_hit_tree u_tree_left (
		.clk     (clk),
		.arst_n  (arst_n),
		.hits    (hit_left_s1),
		.any_hit (any_left)
	);

	ibs_hit_tree u_tree_right (
		.clk     (clk),
		.arst_n  (arst_n),
		.hits    (hit_right_s1),
		.any_hit (any_right)
	);

	always_comb begin
		if (cmd_q == ibs_pkg::CMD_LOAD) begin
			res_status = load_status_q;
		end else if (any_left) begin
			res_status = ibs_pkg::ST_DROP_LEFT;
		end else if (any_right) begin
			res_status = ibs_pkg::ST_DROP_RIGHT;
		end else begin
			res_status = ibs_pkg::ST_KEPT;
		end
	end

	// Output register: a result waits here until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= res_status;
			out_tag_q    <= tag_q;
		end
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.status  = out_status_q;
	assign rsp.tag_out = out_tag_q;

endmodule
